// File: src/rcpi_pkg.sv
package rcpi_pkg;

    localparam int RCPI_PLANE_LIMIT   = 16;
    localparam int RCPI_FRACTION_BITS = 16;
    localparam int COORD_W            = 32;
    localparam int FACE_W             = 4;
    localparam int DIST_W             = 31;
    localparam int CFG_IDX_W          = 3;
    // exact dot product width: 64-bit products, three summed plus offset
    localparam int ACC_W              = 2 * COORD_W + 2;
    localparam int MAG_W              = ACC_W - 1;

    typedef enum logic [1:0] {
        HIT_MISS  = 2'd0,
        HIT_FRONT = 2'd1,
        HIT_BACK  = 2'd2
    } t_hit_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_DIRECTION_X = 3'd3,
        CFG_DIRECTION_Y = 3'd4,
        CFG_DIRECTION_Z = 3'd5,
        CFG_MAX_DIST    = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_SUM,
        FS_PREP,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    // classified plane, handed from front to back
    typedef struct packed {
        logic                      parallel;
        logic                      par_miss;
        logic                      front_face;
        logic signed [COORD_W-1:0] t;
        logic [FACE_W-1:0]         face;
        logic                      last;
    } t_plane_res;

    // queue handshake toward either side
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: src/ray_convex_polyhedron_intersect.sv
// Per plane: setup (multiply, sum, prep), then the bit-serial divider, which yields
// FRACTION_BITS + 65 quotient bits (81 at Q16.16), then the push and the back end.
// A new plane is taken only once the last is pushed; the divider limits throughput.
// Planes parallel to the ray skip the divider.
// Reset (synchronous, active low) clears control, restores default ray registers.
module ray_convex_polyhedron_intersect #(
    parameter int PLANE_LIMIT   = rcpi_pkg::RCPI_PLANE_LIMIT,
    parameter int FRACTION_BITS = rcpi_pkg::RCPI_FRACTION_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // plane channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [rcpi_pkg::COORD_W-1:0]   i_normal_x,
    input  logic signed [rcpi_pkg::COORD_W-1:0]   i_normal_y,
    input  logic signed [rcpi_pkg::COORD_W-1:0]   i_normal_z,
    input  logic signed [rcpi_pkg::COORD_W-1:0]   i_plane_offset,
    input  logic [rcpi_pkg::FACE_W-1:0]           i_face_index,
    input  logic                                  i_last_plane,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_hit_kind,
    output logic signed [rcpi_pkg::COORD_W-1:0]   o_hit_distance,
    output logic [rcpi_pkg::FACE_W-1:0]           o_hit_face,
    // register writes
    input  logic                                  i_cfg_we,
    input  logic [rcpi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rcpi_pkg::COORD_W-1:0]          i_cfg_data
);
    import rcpi_pkg::*;

    // ray registers
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic [DIST_W-1:0]         r_max_dist;

    logic       front_busy, q_push, q_pop;
    t_plane_res front_item, q_item;
    t_q_status  q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox       <= '0;
            r_oy       <= '0;
            r_oz       <= '0;
            r_dx       <= '0;
            r_dy       <= '0;
            r_dz       <= COORD_W'(1) << FRACTION_BITS;   // unit direction along z
            r_max_dist <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ORIGIN_X:    r_ox       <= i_cfg_data;
                CFG_ORIGIN_Y:    r_oy       <= i_cfg_data;
                CFG_ORIGIN_Z:    r_oz       <= i_cfg_data;
                CFG_DIRECTION_X: r_dx       <= i_cfg_data;
                CFG_DIRECTION_Y: r_dy       <= i_cfg_data;
                CFG_DIRECTION_Z: r_dz       <= i_cfg_data;
                CFG_MAX_DIST:    r_max_dist <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // front holds one plane at a time; stall while it works
    assign o_in_stall = front_busy;

    // front: dot products, then t = -vn/vd by restoring division
    rcpi_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_busy     (front_busy),
        .i_nx       (i_normal_x),
        .i_ny       (i_normal_y),
        .i_nz       (i_normal_z),
        .i_w        (i_plane_offset),
        .i_face     (i_face_index),
        .i_last     (i_last_plane),
        .i_ox       (r_ox),
        .i_oy       (r_oy),
        .i_oz       (r_oz),
        .i_dx       (r_dx),
        .i_dy       (r_dy),
        .i_dz       (r_dz),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_item     (front_item)
    );

    // two-entry queue decouples the divider from the bound update
    rcpi_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    // back: near/far bound compare, result register
    rcpi_back #(
        .PLANE_LIMIT(PLANE_LIMIT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (q_item),
        .i_q_status     (q_status),
        .o_pop          (q_pop),
        .i_max_dist     (r_max_dist),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit_kind     (o_hit_kind),
        .o_hit_distance (o_hit_distance),
        .o_hit_face     (o_hit_face)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("plane queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("plane queue underflow");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_kind == HIT_MISS) |-> (o_hit_distance == '0 && o_hit_face == '0))
        else $error("miss result carries distance or face");

    a_front_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_kind == HIT_FRONT) |-> !o_hit_distance[COORD_W-1])
        else $error("entering hit at negative distance");

endmodule

// File: src/rcpi_front.sv
module rcpi_front #(
    parameter int FRACTION_BITS = rcpi_pkg::RCPI_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_busy,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_nx,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_ny,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_nz,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_w,
    input  logic [rcpi_pkg::FACE_W-1:0]         i_face,
    input  logic                                i_last,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_ox,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_oy,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_oz,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_dx,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_dy,
    input  logic signed [rcpi_pkg::COORD_W-1:0] i_dz,
    input  rcpi_pkg::t_q_status                 i_q_status,
    output logic                                o_push,
    output rcpi_pkg::t_plane_res                o_item
);
    import rcpi_pkg::*;

    localparam int NUM_W = MAG_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int PW    = 2 * COORD_W;

    t_front_state r_state, n_state;

    logic signed [COORD_W-1:0] r_nx, r_ny, r_nz, r_w;
    logic [FACE_W-1:0]         r_face;
    logic                      r_last;
    logic signed [PW-1:0]      w_pd0, w_pd1, w_pd2, w_pn0, w_pn1, w_pn2;
    logic signed [ACC_W-1:0]   r_pd0, r_pd1, r_pd2, r_pn0, r_pn1, r_pn2, r_wsh;
    logic signed [ACC_W-1:0]   r_vd, r_vn;
    logic                      r_vd_neg, r_vn_neg, r_vd_zero, r_vn_zero;
    logic [MAG_W-1:0]          r_dmag;
    logic [NUM_W-1:0]          r_num;
    logic [MAG_W:0]            r_rem;
    logic [COORD_W:0]          r_q;
    logic                      r_sat;
    logic [CNT_W-1:0]          r_cnt;

    logic [MAG_W:0]            w_rem2;
    logic                      w_ge;
    logic [ACC_W-1:0]          w_vn_abs, w_vd_abs;
    logic                      w_big, w_tneg;
    logic signed [COORD_W-1:0] w_t;

    assign w_pd0 = r_nx * i_dx;
    assign w_pd1 = r_ny * i_dy;
    assign w_pd2 = r_nz * i_dz;
    assign w_pn0 = r_nx * i_ox;
    assign w_pn1 = r_ny * i_oy;
    assign w_pn2 = r_nz * i_oz;

    assign w_vn_abs = r_vn[ACC_W-1] ? (~r_vn + ACC_W'(1)) : r_vn;
    assign w_vd_abs = r_vd[ACC_W-1] ? (~r_vd + ACC_W'(1)) : r_vd;

    // restoring division step, one quotient bit per cycle
    assign w_rem2 = {r_rem[MAG_W-1:0], r_num[NUM_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_dmag};

    // quotient saturation: anything at or above 2^31 clips
    assign w_big  = r_sat | r_q[COORD_W] | r_q[COORD_W-1];
    assign w_tneg = !r_vn_zero && (r_vn_neg == r_vd_neg);
    always_comb begin
        if (w_tneg) begin
            w_t = w_big ? {1'b1, {(COORD_W-1){1'b0}}}
                        : -$signed({1'b0, r_q[COORD_W-2:0]});
        end else begin
            w_t = (w_big || (&r_q[COORD_W-2:0])) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                  : $signed({1'b0, r_q[COORD_W-2:0]});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (i_valid) n_state = FS_MUL;
            FS_MUL:  n_state = FS_SUM;
            FS_SUM:  n_state = FS_PREP;
            FS_PREP: n_state = (r_vd == '0) ? FS_PUSH : FS_DIV;
            FS_DIV:  if (r_cnt == '0) n_state = FS_PUSH;
            FS_PUSH: if (!i_q_status.full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != FS_IDLE);
        o_push = (r_state == FS_PUSH) && !i_q_status.full;
        o_item.parallel   = r_vd_zero;
        o_item.par_miss   = !r_vn_zero && !r_vn_neg;
        o_item.front_face = r_vd_neg;
        o_item.t          = w_t;
        o_item.face       = r_face;
        o_item.last       = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            FS_IDLE: begin
                r_nx   <= i_nx;
                r_ny   <= i_ny;
                r_nz   <= i_nz;
                r_w    <= i_w;
                r_face <= i_face;
                r_last <= i_last;
            end
            FS_MUL: begin
                r_pd0 <= {{(ACC_W-PW){w_pd0[PW-1]}}, w_pd0};
                r_pd1 <= {{(ACC_W-PW){w_pd1[PW-1]}}, w_pd1};
                r_pd2 <= {{(ACC_W-PW){w_pd2[PW-1]}}, w_pd2};
                r_pn0 <= {{(ACC_W-PW){w_pn0[PW-1]}}, w_pn0};
                r_pn1 <= {{(ACC_W-PW){w_pn1[PW-1]}}, w_pn1};
                r_pn2 <= {{(ACC_W-PW){w_pn2[PW-1]}}, w_pn2};
                r_wsh <= {{(ACC_W-COORD_W){r_w[COORD_W-1]}}, r_w} <<< FRACTION_BITS;
            end
            FS_SUM: begin
                r_vd <= r_pd0 + r_pd1 + r_pd2;
                r_vn <= r_pn0 + r_pn1 + r_pn2 + r_wsh;
            end
            FS_PREP: begin
                r_vd_neg  <= r_vd[ACC_W-1];
                r_vn_neg  <= r_vn[ACC_W-1];
                r_vd_zero <= (r_vd == '0);
                r_vn_zero <= (r_vn == '0);
                r_dmag    <= w_vd_abs[MAG_W-1:0];
                r_num     <= {w_vn_abs[MAG_W-1:0], {FRACTION_BITS{1'b0}}};
                r_rem     <= '0;
                r_q       <= '0;
                r_sat     <= 1'b0;
                r_cnt     <= CNT_W'(NUM_W - 1);
            end
            FS_DIV: begin
                r_rem <= w_ge ? (w_rem2 - {1'b0, r_dmag}) : w_rem2;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_q   <= {r_q[COORD_W-1:0], w_ge};
                r_sat <= r_sat | r_q[COORD_W];
                r_cnt <= r_cnt - CNT_W'(1);
            end
            FS_PUSH: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/rcpi_queue.sv
module rcpi_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rcpi_pkg::t_plane_res i_item,
    input  logic                 i_pop,
    output rcpi_pkg::t_plane_res o_item,
    output rcpi_pkg::t_q_status  o_status
);
    import rcpi_pkg::*;

    t_plane_res r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_item          = r_mem[r_rd];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: src/rcpi_back.sv
module rcpi_back #(
    parameter int PLANE_LIMIT = rcpi_pkg::RCPI_PLANE_LIMIT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rcpi_pkg::t_plane_res                i_item,
    input  rcpi_pkg::t_q_status                 i_q_status,
    output logic                                o_pop,
    input  logic [rcpi_pkg::DIST_W-1:0]         i_max_dist,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_hit_kind,
    output logic signed [rcpi_pkg::COORD_W-1:0] o_hit_distance,
    output logic [rcpi_pkg::FACE_W-1:0]         o_hit_face
);
    import rcpi_pkg::*;

    localparam int PC_W = $clog2(PLANE_LIMIT + 1);

    logic signed [COORD_W-1:0] r_near, r_far;
    logic [FACE_W-1:0]         r_near_face, r_far_face;
    logic                      r_missed, r_in_poly;
    logic [PC_W-1:0]           r_count;

    logic signed [COORD_W-1:0] w_near, w_far, w_near_n, w_far_n, w_max;
    logic [FACE_W-1:0]         w_nf, w_ff, w_nf_n, w_ff_n;
    logic                      w_missed, w_missed_n, w_last;
    logic [PC_W-1:0]           w_cnt;
    t_hit_kind                 w_kind;
    logic signed [COORD_W-1:0] w_dist;
    logic [FACE_W-1:0]         w_face;

    assign w_max = $signed({1'b0, i_max_dist});

    // fresh bounds at the first plane of a polyhedron
    always_comb begin
        if (r_in_poly) begin
            w_near   = r_near;
            w_far    = r_far;
            w_nf     = r_near_face;
            w_ff     = r_far_face;
            w_missed = r_missed;
            w_cnt    = r_count + PC_W'(1);
        end else begin
            w_near   = {1'b1, {(COORD_W-1){1'b0}}};
            w_far    = w_max;
            w_nf     = '0;
            w_ff     = '0;
            w_missed = 1'b0;
            w_cnt    = PC_W'(1);
        end
        w_last = i_item.last || (w_cnt >= PC_W'(PLANE_LIMIT));
    end

    always_comb begin
        w_near_n   = w_near;
        w_far_n    = w_far;
        w_nf_n     = w_nf;
        w_ff_n     = w_ff;
        w_missed_n = w_missed;
        if (!w_missed) begin
            if (i_item.parallel) begin
                w_missed_n = i_item.par_miss;
            end else if (i_item.front_face) begin
                if (i_item.t > w_far) begin
                    w_missed_n = 1'b1;
                end else if (i_item.t > w_near) begin
                    w_near_n = i_item.t;
                    w_nf_n   = i_item.face;
                end
            end else begin
                if (i_item.t < w_near) begin
                    w_missed_n = 1'b1;
                end else if (i_item.t < w_far) begin
                    w_far_n = i_item.t;
                    w_ff_n  = i_item.face;
                end
            end
        end
    end

    always_comb begin
        w_kind = HIT_MISS;
        w_dist = '0;
        w_face = '0;
        if (!w_missed_n) begin
            if (!w_near_n[COORD_W-1]) begin
                w_kind = HIT_FRONT;
                w_dist = w_near_n;
                w_face = w_nf_n;
            end else if (w_far_n < w_max) begin
                w_kind = HIT_BACK;
                w_dist = w_far_n;
                w_face = w_ff_n;
            end
        end
    end

    assign o_pop = !i_q_status.empty && (!w_last || !o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_poly   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= (o_pop && w_last) || (o_out_valid && i_out_stall);
            if (o_pop) begin
                r_in_poly <= !w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_near      <= w_near_n;
            r_far       <= w_far_n;
            r_near_face <= w_nf_n;
            r_far_face  <= w_ff_n;
            r_missed    <= w_missed_n;
            r_count     <= w_cnt;
            if (w_last) begin
                o_hit_kind     <= w_kind;
                o_hit_distance <= w_dist;
                o_hit_face     <= w_face;
            end
        end
    end

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpi_pkg::*;

    localparam int  CLIP_LIMIT  = 16;
    localparam int  FRAC        = 16;
    localparam int  SETTLE      = 120;     // a bit more than one plane's latency
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PHASES      = 8;
    localparam int  PER_PHASE   = 50;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_hit_kind          kind;
        logic signed [31:0] distance;
        logic [3:0]         face;
    } hit_t;

    // one row of the directed table; typed hit used only when pinned is set
    typedef struct {
        logic signed [31:0] nx, ny, nz, w;
        logic [3:0]         face;
        logic               last;
        logic               pinned;
        hit_t               hit;
    } row_t;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall;
    logic signed [31:0] i_normal_x, i_normal_y, i_normal_z, i_plane_offset;
    logic [3:0] i_face_index;
    logic i_last_plane;
    logic o_out_valid, i_out_stall;
    logic [1:0] o_hit_kind;
    logic signed [31:0] o_hit_distance;
    logic [3:0] o_hit_face;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    ray_convex_polyhedron_intersect dut (.*);

    // shadow registers and clip state of the predictor
    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    longint             ray_tmax;
    longint             t_near, t_far;
    logic [3:0]         face_near, face_far;
    bit                 ray_missed, in_hull;
    int                 hull_planes;

    hit_t   hits_due [$];
    int     fails;
    int     cycles;
    bit     quiet;      // no idling on either side
    int     stall_left;
    row_t   rows [14];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[ray_convex_polyhedron_intersect] ERROR");
            $finish;
        end
    end

    // receiver stalls in short bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result transfer: compare with the oldest pending hit
    always @(posedge i_clk) begin
        hit_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (hits_due.size() == 0) begin
                $error("unexpected result kind=%0d", o_hit_kind);
                fails++;
            end else begin
                e = hits_due.pop_front();
                if (o_hit_kind !== e.kind) begin
                    $error("hit_kind exp %0d got %0d", e.kind, o_hit_kind);
                    fails++;
                end
                if (o_hit_distance !== e.distance) begin
                    $error("hit_distance exp %0d got %0d", e.distance, o_hit_distance);
                    fails++;
                end
                if (o_hit_face !== e.face) begin
                    $error("hit_face exp %0d got %0d", e.face, o_hit_face);
                    fails++;
                end
            end
        end
    end

    function automatic void hull_restart();
        t_near      = -64'sd2147483648;
        t_far       = ray_tmax;
        face_near   = '0;
        face_far    = '0;
        ray_missed  = 0;
        hull_planes = 0;
    endfunction

    // clip the ray by one plane; returns 1 with the hit when the hull closes
    function automatic bit clip_plane(input logic signed [31:0] nx, ny, nz, w,
                                      input logic [3:0] face, input logic last,
                                      output hit_t hit);
        logic signed [66:0] vd, vn, wx;
        logic [66:0]        mvd, mvn;
        logic [90:0]        q;
        longint             t;
        bit                 closes, t_neg;
        if (!in_hull) begin
            hull_restart();
            in_hull = 1;
        end
        hull_planes++;
        closes = last || (hull_planes >= CLIP_LIMIT);
        if (!ray_missed) begin
            vd = longint'(ray_dir[0]) * longint'(nx);
            vd = vd + longint'(ray_dir[1]) * longint'(ny);
            vd = vd + longint'(ray_dir[2]) * longint'(nz);
            vn = longint'(ray_org[0]) * longint'(nx);
            vn = vn + longint'(ray_org[1]) * longint'(ny);
            vn = vn + longint'(ray_org[2]) * longint'(nz);
            wx = w;
            wx = wx <<< FRAC;
            vn = vn + wx;
            if (vd == 0) begin
                if (vn > 0) ray_missed = 1;
            end else begin
                mvd = (vd < 0) ? -vd : vd;
                mvn = (vn < 0) ? -vn : vn;
                q = (91'(mvn) << FRAC) / 91'(mvd);
                if (q > 91'h1_0000_0000) q = 91'h1_0000_0000;
                t_neg = (vn != 0) && ((vn < 0) == (vd < 0));
                if (t_neg) t = (q >= 91'h8000_0000) ? -64'sd2147483648 : -longint'(q);
                else       t = (q >= 91'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
                if (vd < 0) begin
                    if (t > t_far) ray_missed = 1;
                    else if (t > t_near) begin
                        t_near = t;
                        face_near = face;
                    end
                end else begin
                    if (t < t_near) ray_missed = 1;
                    else if (t < t_far) begin
                        t_far = t;
                        face_far = face;
                    end
                end
            end
        end
        hit = '{HIT_MISS, '0, '0};
        if (closes) begin
            if (!ray_missed) begin
                if (t_near >= 0) hit = '{HIT_FRONT, t_near[31:0], face_near};
                else if (t_far < ray_tmax) hit = '{HIT_BACK, t_far[31:0], face_far};
            end
            in_hull = 0;
        end
        return closes;
    endfunction

    // one plane transfer; the plane is clipped in the predictor on acceptance
    task automatic send_plane(input logic signed [31:0] nx, ny, nz, w,
                              input logic [3:0] face, input logic last,
                              input bit pinned, input hit_t pin_hit);
        hit_t h;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_normal_x     <= nx;
        i_normal_y     <= ny;
        i_normal_z     <= nz;
        i_plane_offset <= w;
        i_face_index   <= face;
        i_last_plane   <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (clip_plane(nx, ny, nz, w, face, last, h))
            hits_due.push_back(pinned ? pin_hit : h);
    endtask

    // wait out all pending hits plus one latency, with the input idle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; load_ray drops it
    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ORIGIN_X:    ray_org[0] = val;
            CFG_ORIGIN_Y:    ray_org[1] = val;
            CFG_ORIGIN_Z:    ray_org[2] = val;
            CFG_DIRECTION_X: ray_dir[0] = val;
            CFG_DIRECTION_Y: ray_dir[1] = val;
            CFG_DIRECTION_Z: ray_dir[2] = val;
            CFG_MAX_DIST:    ray_tmax = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    function automatic logic [31:0] near_unit();
        return $urandom_range(0, 2 * 65536) - 65536;
    endfunction

    // ray setup per phase: in-box, extremes, zero direction, fully random
    task automatic load_ray(input int phase);
        case (phase % 4)
            0: begin
                write_reg(CFG_ORIGIN_X, 2 * near_unit());
                write_reg(CFG_ORIGIN_Y, 2 * near_unit());
                write_reg(CFG_ORIGIN_Z, 2 * near_unit());
                write_reg(CFG_DIRECTION_X, near_unit());
                write_reg(CFG_DIRECTION_Y, near_unit());
                write_reg(CFG_DIRECTION_Z, near_unit());
                write_reg(CFG_MAX_DIST, $urandom_range(0, 40 * 65536));
            end
            1: begin
                write_reg(CFG_ORIGIN_X, SMIN);
                write_reg(CFG_ORIGIN_Y, SMAX);
                write_reg(CFG_ORIGIN_Z, SMIN);
                write_reg(CFG_DIRECTION_X, SMAX);
                write_reg(CFG_DIRECTION_Y, SMIN);
                write_reg(CFG_DIRECTION_Z, SMAX);
                write_reg(CFG_MAX_DIST, 32'd0);
            end
            2: begin
                write_reg(CFG_ORIGIN_X, near_unit());
                write_reg(CFG_ORIGIN_Y, near_unit());
                write_reg(CFG_ORIGIN_Z, near_unit());
                write_reg(CFG_DIRECTION_X, 32'd0);
                write_reg(CFG_DIRECTION_Y, 32'd0);
                write_reg(CFG_DIRECTION_Z, 32'd0);
                write_reg(CFG_MAX_DIST, 32'hFFFF_FFFF);
            end
            default: begin
                write_reg(CFG_ORIGIN_X, $urandom());
                write_reg(CFG_ORIGIN_Y, $urandom());
                write_reg(CFG_ORIGIN_Z, $urandom());
                write_reg(CFG_DIRECTION_X, $urandom());
                write_reg(CFG_DIRECTION_Y, $urandom());
                write_reg(CFG_DIRECTION_Z, $urandom());
                write_reg(CFG_MAX_DIST, $urandom());
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    // one normal component: mostly axis-like or small, sometimes raw bits
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return ONE;
            2:       return -ONE;
            3, 4:    return near_unit();
            default: return $urandom();
        endcase
    endfunction

    initial begin
        hit_t none;
        int   sent, len;
        none = '{HIT_MISS, '0, '0};
        fails = 0; cycles = 0; quiet = 0; stall_left = 0;
        i_rst_n = 0; i_in_valid = 0; i_out_stall = 0; i_cfg_we = 0;
        i_cfg_index = '0; i_cfg_data = '0;
        i_normal_x = '0; i_normal_y = '0; i_normal_z = '0; i_plane_offset = '0;
        i_face_index = '0; i_last_plane = 0;
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, ONE};
        ray_tmax = 64'sd2147483647;
        in_hull = 0;
        hull_restart();

        // directed rows under the reset ray: origin 0, direction +z
        rows[0]  = '{0, 0, -ONE, 5 * ONE, 4'd3, 1, 1, '{HIT_FRONT, 5 * ONE, 4'd3}};
        rows[1]  = '{ONE, 0, 0, ONE, 4'd0, 1, 1, '{HIT_MISS, 0, 0}};    // parallel, outside
        rows[2]  = '{ONE, 0, 0, -ONE, 4'd0, 1, 1, '{HIT_MISS, 0, 0}};   // parallel, inside
        rows[3]  = '{0, 0, ONE, -3 * ONE, 4'd7, 1, 1, '{HIT_BACK, 3 * ONE, 4'd7}};
        // tie: the earlier face keeps the near bound
        rows[4]  = '{0, 0, -ONE, 2 * ONE, 4'd1, 0, 0, none};
        rows[5]  = '{0, 0, -ONE, 2 * ONE, 4'd2, 1, 1, '{HIT_FRONT, 2 * ONE, 4'd1}};
        // bounds cross, then a plane after the miss
        rows[6]  = '{0, 0, -ONE, 5 * ONE, 4'd4, 0, 0, none};
        rows[7]  = '{0, 0, ONE, -3 * ONE, 4'd5, 0, 0, none};
        rows[8]  = '{0, 0, -ONE, ONE, 4'd6, 1, 1, '{HIT_MISS, 0, 0}};
        rows[9]  = '{SMIN, SMIN, SMIN, SMIN, 4'd15, 1, 0, none};
        rows[10] = '{SMAX, SMAX, SMAX, SMAX, 4'd0, 1, 0, none};
        rows[11] = '{0, 0, -32'sd1, SMAX, 4'd9, 1, 0, none};     // t saturates high
        rows[12] = '{0, 0, -32'sd1, SMIN, 4'd10, 1, 0, none};    // t saturates low
        rows[13] = '{0, 0, 0, 0, 4'd0, 1, 1, '{HIT_MISS, 0, 0}};  // degenerate plane

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r])
            send_plane(rows[r].nx, rows[r].ny, rows[r].nz, rows[r].w,
                       rows[r].face, rows[r].last, rows[r].pinned, rows[r].hit);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph == PHASES - 1);
            load_ray(ph);
            sent = 0;
            while (sent < PER_PHASE) begin
                // whole hulls only; now and then one runs into the plane limit
                len = ($urandom_range(0, 9) == 0) ? CLIP_LIMIT + 1 : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_plane(pick_comp(), pick_comp(), pick_comp(),
                               ($urandom_range(0, 3) == 0) ? $urandom()
                                                           : 8 * near_unit(),
                               $urandom_range(0, 15), k == len - 1, 0, none);
                end
                sent += len;
            end
            drain();
        end

        if (fails == 0 && hits_due.size() == 0)
            $display("[ray_convex_polyhedron_intersect] OK");
        else
            $display("[ray_convex_polyhedron_intersect] ERROR");
        $finish;
    end
endmodule

// File: sim.f
src/rcpi_pkg.sv
src/rcpi_front.sv
src/rcpi_queue.sv
src/rcpi_back.sv
src/ray_convex_polyhedron_intersect.sv
dv/tb.sv
